// File: rtl/fsq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Four-square pair cipher package
// Shared widths, request codes and item types of the four-square cipher core.
// ----------------------------------------------------------------------------
package fsq_pkg;

    localparam int SYM_W       = 8;
    localparam int SIDE_DEFAULT = 5;

    // Request codes.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_XFORM = 1'b1;

    // Square selects for a load item.
    localparam logic [1:0] TBL_PLAIN = 2'd0;
    localparam logic [1:0] TBL_KEY1  = 2'd1;
    localparam logic [1:0] TBL_KEY2  = 2'd2;

    // Mode register codes.
    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [1:0]       table_select;
        logic [4:0]       entry_index;
        logic [SYM_W-1:0] first_symbol;
        logic [SYM_W-1:0] second_symbol;
        logic             lone_symbol;
    } req_item_t;

    typedef struct packed {
        logic [SYM_W-1:0] out_first;
        logic [SYM_W-1:0] out_second;
        logic             out_lone;
    } rsp_item_t;

endpackage
`default_nettype wire

// File: rtl/four_square_pair_cipher_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Four-square pair cipher core
// Holds a plain square and two key squares and enciphers or deciphers pairs.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (req_valid, req_stall, req_item) carries load items,
// which write one cell of a square, and transform items, which carry a pair.
// The response channel (rsp_valid, rsp_stall, rsp_item) returns one item per
// transform item; a load item returns nothing. cfg_wr_en with cfg_wr_data
// sets the mode (encipher or decipher) and must be written only while idle;
// the core itself does not enforce this. A lone symbol goes from idle
// straight to the done state, where its result is registered. For a pair,
// every cell of the searched squares is read once through the memory's scan
// port, both symbols compared in the same pass, then the two crossed cells
// are read. One item is worked on at a time.
// The result sits in an output register, so a new item is accepted while it
// waits; a stalled receiver holds the next result in the done state.
// Reset clears the mode to encipher and makes every cell read as zero.
// ----------------------------------------------------------------------------
module four_square_pair_cipher_core #(
    parameter int SQUARE_SIDE = fsq_pkg::SIDE_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic               cfg_wr_data,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire fsq_pkg::req_item_t req_item,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output fsq_pkg::rsp_item_t      rsp_item
);

    localparam int CELLS = SQUARE_SIDE * SQUARE_SIDE;
    localparam int IDX_W = $clog2(CELLS);
    localparam int COL_W = $clog2(SQUARE_SIDE);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SEARCH = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_READ   = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic                      mode_reg;
    logic                      req_accept;
    logic                      rsp_free;

    // Item held while it is worked on.
    logic [fsq_pkg::SYM_W-1:0] sym0_reg, sym1_reg;
    logic                      lone_reg;

    // Scan position of the address being issued.
    logic [IDX_W-1:0]          scan_idx_reg;
    logic [IDX_W-1:0]          scan_base_reg;
    logic [COL_W-1:0]          scan_col_reg;
    // Position of the data coming back from the memories.
    logic                      cmp_pend_reg;
    logic [IDX_W-1:0]          cmp_base_reg;
    logic [COL_W-1:0]          cmp_col_reg;

    // First match of each symbol: row base and column.
    logic                      hit0_reg, hit1_reg;
    logic [IDX_W-1:0]          base0_reg, base1_reg;
    logic [COL_W-1:0]          col0_reg, col1_reg;

    logic                      rsp_valid_reg;
    fsq_pkg::rsp_item_t        rsp_item_reg;

    logic                      load_ok;
    logic                      wr_plain, wr_key1, wr_key2;
    logic [IDX_W-1:0]          wr_addr;
    logic [IDX_W-1:0]          addr_a, addr_b;
    logic [IDX_W-1:0]          cross0, cross1;
    logic [fsq_pkg::SYM_W-1:0] plain_a, plain_b, key1_a, key1_b, key2_a, key2_b;
    logic [fsq_pkg::SYM_W-1:0] cmp0_data, cmp1_data;
    logic                      match0, match1;

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;

    // Memory ports.
    assign load_ok  = req_accept && (req_item.req_type == fsq_pkg::REQ_LOAD)
                      && (32'(req_item.entry_index) < 32'(CELLS));
    assign wr_plain = load_ok && (req_item.table_select == fsq_pkg::TBL_PLAIN);
    assign wr_key1  = load_ok && (req_item.table_select == fsq_pkg::TBL_KEY1);
    assign wr_key2  = load_ok && (req_item.table_select == fsq_pkg::TBL_KEY2);
    assign wr_addr  = IDX_W'(req_item.entry_index);

    // Row of one symbol with the column of the other.
    assign cross0 = base0_reg + IDX_W'(col1_reg);
    assign cross1 = base1_reg + IDX_W'(col0_reg);

    assign addr_a = (state_reg == ST_SEARCH) ? scan_idx_reg : cross0;
    assign addr_b = cross1;

    fsq_square_mem #(.CELLS(CELLS), .IDX_W(IDX_W)) u_plain (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_plain),
        .wr_addr   (wr_addr),
        .wr_data   (req_item.first_symbol),
        .rd_addr_a (addr_a),
        .rd_addr_b (addr_b),
        .rd_data_a (plain_a),
        .rd_data_b (plain_b)
    );

    // Key one's second port reads the crossed cell of the first output.
    fsq_square_mem #(.CELLS(CELLS), .IDX_W(IDX_W)) u_key1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_key1),
        .wr_addr   (wr_addr),
        .wr_data   (req_item.first_symbol),
        .rd_addr_a (addr_a),
        .rd_addr_b (cross0),
        .rd_data_a (key1_a),
        .rd_data_b (key1_b)
    );

    fsq_square_mem #(.CELLS(CELLS), .IDX_W(IDX_W)) u_key2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_key2),
        .wr_addr   (wr_addr),
        .wr_data   (req_item.first_symbol),
        .rd_addr_a (addr_a),
        .rd_addr_b (addr_b),
        .rd_data_a (key2_a),
        .rd_data_b (key2_b)
    );

    // Enciphering searches the plain square for both symbols; deciphering
    // searches key one for the first and key two for the second.
    assign cmp0_data = (mode_reg == fsq_pkg::MODE_DEC) ? key1_a : plain_a;
    assign cmp1_data = (mode_reg == fsq_pkg::MODE_DEC) ? key2_a : plain_a;
    assign match0    = cmp_pend_reg && !hit0_reg && (cmp0_data == sym0_reg);
    assign match1    = cmp_pend_reg && !hit1_reg && (cmp1_data == sym1_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept && (req_item.req_type == fsq_pkg::REQ_XFORM))
                begin
                    state_next = req_item.lone_symbol ? ST_DONE : ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (scan_idx_reg == IDX_W'(CELLS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= fsq_pkg::MODE_ENC;
            rsp_valid_reg <= 1'b0;
            cmp_pend_reg  <= 1'b0;
            hit0_reg      <= 1'b0;
            hit1_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            if ((state_reg == ST_DONE) && rsp_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            cmp_pend_reg <= (state_reg == ST_SEARCH);
            if (req_accept)
            begin
                hit0_reg <= 1'b0;
                hit1_reg <= 1'b0;
            end
            else
            begin
                if (match0)
                begin
                    hit0_reg <= 1'b1;
                end
                if (match1)
                begin
                    hit1_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            sym0_reg      <= req_item.first_symbol;
            sym1_reg      <= req_item.second_symbol;
            lone_reg      <= req_item.lone_symbol;
            scan_idx_reg  <= '0;
            scan_base_reg <= '0;
            scan_col_reg  <= '0;
            // A symbol that is never found stays at cell zero.
            base0_reg     <= '0;
            base1_reg     <= '0;
            col0_reg      <= '0;
            col1_reg      <= '0;
        end
        else
        begin
            if (state_reg == ST_SEARCH)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                if (scan_col_reg == COL_W'(SQUARE_SIDE - 1))
                begin
                    scan_col_reg  <= '0;
                    scan_base_reg <= scan_base_reg + IDX_W'(SQUARE_SIDE);
                end
                else
                begin
                    scan_col_reg <= scan_col_reg + COL_W'(1);
                end
            end
            if (match0)
            begin
                base0_reg <= cmp_base_reg;
                col0_reg  <= cmp_col_reg;
            end
            if (match1)
            begin
                base1_reg <= cmp_base_reg;
                col1_reg  <= cmp_col_reg;
            end
        end
        cmp_base_reg <= scan_base_reg;
        cmp_col_reg  <= scan_col_reg;

        if ((state_reg == ST_DONE) && rsp_free)
        begin
            if (lone_reg)
            begin
                rsp_item_reg.out_first  <= sym0_reg;
                rsp_item_reg.out_second <= '0;
                rsp_item_reg.out_lone   <= 1'b1;
            end
            else if (mode_reg == fsq_pkg::MODE_DEC)
            begin
                rsp_item_reg.out_first  <= plain_a;
                rsp_item_reg.out_second <= plain_b;
                rsp_item_reg.out_lone   <= 1'b0;
            end
            else
            begin
                rsp_item_reg.out_first  <= key1_b;
                rsp_item_reg.out_second <= key2_b;
                rsp_item_reg.out_lone   <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    // The scan ends on the last cell and always drains and reads after it.
    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) && (scan_idx_reg == IDX_W'(CELLS - 1))
        |=> (state_reg == ST_DRAIN))
        else $error("scan did not end on the last cell");

    a_drain_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |=> (state_reg == ST_READ) ##1 (state_reg == ST_DONE))
        else $error("drain was not followed by the crossed read");

    // A pair starts a scan; a lone symbol goes straight to the result.
    a_pair_start: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept && (req_item.req_type == fsq_pkg::REQ_XFORM) && !req_item.lone_symbol
        |=> (state_reg == ST_SEARCH) && (scan_idx_reg == '0))
        else $error("pair item did not start a scan");

    // The first match is kept for the rest of the scan.
    a_hit_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) && hit0_reg |=> hit0_reg && $stable(base0_reg))
        else $error("first match of the first symbol was lost");

    // Results are only produced from the done state.
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside the done state");

endmodule
`default_nettype wire

// File: rtl/fsq_square_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Square memory
// One cipher square: one write port, two registered read ports. Entries that
// were never written since reset read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module fsq_square_mem #(
    parameter int CELLS = 25,
    parameter int IDX_W = 5
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     wr_en,
    input  wire logic [IDX_W-1:0]         wr_addr,
    input  wire logic [fsq_pkg::SYM_W-1:0] wr_data,
    input  wire logic [IDX_W-1:0]         rd_addr_a,
    input  wire logic [IDX_W-1:0]         rd_addr_b,
    output logic      [fsq_pkg::SYM_W-1:0] rd_data_a,
    output logic      [fsq_pkg::SYM_W-1:0] rd_data_b
);

    logic [fsq_pkg::SYM_W-1:0] mem [CELLS];
    logic [CELLS-1:0]          valid_reg;
    logic [fsq_pkg::SYM_W-1:0] rd_a_reg;
    logic [fsq_pkg::SYM_W-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= valid_reg[rd_addr_a] ? mem[rd_addr_a] : '0;
        rd_b_reg <= valid_reg[rd_addr_b] ? mem[rd_addr_b] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule
`default_nettype wire
